### rtl/cptm_pkg.sv
// Shared types and constants of the capture period trimmed-mean meter.
package cptm_pkg;

  localparam int unsigned SAMPLES  = 8;
  localparam int unsigned DIV      = SAMPLES - 2;
  localparam int unsigned STAMP_W  = 16;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned CNT_W    = 7;

  localparam logic [PERIOD_W-1:0] COUNTER_TOP_RESET = PERIOD_W'(65536);

  // floor(x / DIV) = (x * DIV_MULT) >> DIV_SHIFT for every SUM_W-bit x
  localparam int unsigned DIV_SHIFT  = SUM_W + $clog2(DIV);
  localparam longint      DIV_MULT_L = ((longint'(1) << DIV_SHIFT) + longint'(DIV) - 1)
                                       / longint'(DIV);
  localparam logic [SUM_W:0] DIV_MULT = (SUM_W+1)'(DIV_MULT_L);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PERIOD,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

endpackage

### rtl/cptm_front.sv
// Front end: accepts transactions, pairs capture edges and measures periods.
module cptm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cptm_pkg::PERIOD_W-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [cptm_pkg::STAMP_W-1:0]   capture_stamp,
  input  logic                           counter_wrapped,
  output logic                           cmd_valid,
  output cptm_pkg::cmd_t                 cmd,
  input  logic                           cmd_full
);
  import cptm_pkg::*;

  logic [PERIOD_W-1:0] counter_top;
  logic                pair_phase;
  logic [STAMP_W-1:0]  first_stamp;
  logic                accept;
  logic [PERIOD_W-1:0] period;
  logic [STAMP_W-1:0]  plain_diff;

  assign in_stall  = cmd_full;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && !cmd_full;

  assign plain_diff = capture_stamp - first_stamp;

  always_comb begin
    if (counter_wrapped) begin
      period = counter_top - PERIOD_W'(first_stamp) + PERIOD_W'(capture_stamp);
    end else begin
      period = PERIOD_W'(plain_diff);
    end
    cmd.period = period;
    if (func) begin
      cmd.op = OP_CLEAR;
    end else if (pair_phase) begin
      cmd.op = OP_PERIOD;
    end else begin
      cmd.op = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top <= COUNTER_TOP_RESET;
      pair_phase  <= 1'b0;
      first_stamp <= '0;
    end else begin
      if (cfg_wr_en) begin
        counter_top <= cfg_wr_data;
      end
      if (accept && !func) begin
        pair_phase <= !pair_phase;
        if (!pair_phase) begin
          first_stamp <= capture_stamp;
        end
      end
    end
  end

endmodule

### rtl/cptm_queue.sv
// Two-entry command queue between front end and back end.
module cptm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cptm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cptm_pkg::cmd_t pop_cmd
);
  import cptm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/cptm_back.sv
// Back end: batch statistics, trimmed-mean divide and result register.
module cptm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  cptm_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cptm_pkg::PERIOD_W-1:0]  average_period,
  output logic                           updated
);
  import cptm_pkg::*;

  typedef struct packed {
    logic                clear;
    logic                done;
    logic                equal;
    logic [PERIOD_W-1:0] max_val;
    logic [SUM_W-1:0]    trimmed;
  } stat_t;

  logic [CNT_W-1:0]    sample_count;
  logic [SUM_W-1:0]    running_sum;
  logic [PERIOD_W-1:0] running_max;
  logic [PERIOD_W-1:0] running_min;

  logic [CNT_W-1:0]    count_next;
  logic [SUM_W-1:0]    sum_next;
  logic [PERIOD_W-1:0] max_next;
  logic [PERIOD_W-1:0] min_next;
  logic                batch_done;

  logic                stat_valid;
  stat_t               stat;
  stat_t               stat_next;

  logic                out_adv;
  logic                stat_adv;
  logic [2*SUM_W:0]    product;
  logic [PERIOD_W-1:0] quotient;

  assign out_adv  = !out_valid || !out_stall;
  assign stat_adv = !stat_valid || out_adv;
  assign cmd_pop  = cmd_valid && stat_adv;

  always_comb begin
    count_next = sample_count + CNT_W'(1);
    sum_next   = running_sum + SUM_W'(cmd.period);
    max_next   = (cmd.period > running_max) ? cmd.period : running_max;
    min_next   = (cmd.period < running_min) ? cmd.period : running_min;
    batch_done = (cmd.op == OP_PERIOD) && (count_next == CNT_W'(SAMPLES));

    stat_next.clear   = (cmd.op == OP_CLEAR);
    stat_next.done    = batch_done;
    stat_next.equal   = (max_next == min_next);
    stat_next.max_val = max_next;
    stat_next.trimmed = sum_next - SUM_W'(max_next) - SUM_W'(min_next);
  end

  assign product  = stat.trimmed * DIV_MULT;
  assign quotient = product[DIV_SHIFT +: PERIOD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      running_sum    <= '0;
      running_max    <= '0;
      running_min    <= '1;
      stat_valid     <= 1'b0;
      out_valid      <= 1'b0;
      average_period <= '0;
      updated        <= 1'b0;
    end else begin
      if (cmd_pop) begin
        stat <= stat_next;
        if (batch_done) begin
          sample_count <= '0;
          running_sum  <= '0;
          running_max  <= '0;
          running_min  <= '1;
        end else if (cmd.op == OP_PERIOD) begin
          sample_count <= count_next;
          running_sum  <= sum_next;
          running_max  <= max_next;
          running_min  <= min_next;
        end
      end
      if (stat_adv) begin
        stat_valid <= cmd_valid;
      end
      if (out_adv) begin
        out_valid <= stat_valid;
        if (stat_valid) begin
          updated <= stat.done;
          if (stat.clear) begin
            average_period <= '0;
          end else if (stat.done) begin
            average_period <= stat.equal ? stat.max_val : quotient;
          end
        end
      end
    end
  end

endmodule

### rtl/capture_period_trimmed_mean.sv
// Capture period meter with trimmed-mean filter, top level.
// Each result is held in the command queue, then the stat and output registers.
// Throughput: one transaction per cycle while in_stall is low, kept up by the
// batch update and the one-multiply constant divide in the back end.
// Reset: counter_top returns to 65536, pairing and batch restart, published period
// is zero; the block accepts transactions in the first cycle after reset.
module capture_period_trimmed_mean (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cptm_pkg::PERIOD_W-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [cptm_pkg::STAMP_W-1:0]   capture_stamp,
  input  logic                           counter_wrapped,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cptm_pkg::PERIOD_W-1:0]  average_period,
  output logic                           updated
);
  import cptm_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  cmd_t q_cmd;

  cptm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .capture_stamp   (capture_stamp),
    .counter_wrapped (counter_wrapped),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_full        (q_full)
  );

  cptm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_cmd  (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd)
  );

  cptm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_not_empty),
    .cmd            (q_cmd),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .average_period (average_period),
    .updated        (updated)
  );

endmodule
